@@ rtl/shrp_pkg.sv @@
// ----------------------------------------------------------------------------
// shrp_pkg
// shared types, constants and id tables of the sensor hub report parser
// ----------------------------------------------------------------------------
package shrp_pkg;

  localparam int MAX_PACKET_BYTES = 512;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
  localparam logic [4:0] SKIP_RESET = 5'd5;

  typedef enum logic [1:0] {
    OUTC_DECODED   = 2'd0,
    OUTC_UNKNOWN   = 2'd1,
    OUTC_TRUNCATED = 2'd2
  } outcome_t;

  typedef logic [15:1][7:0] rpt_bytes_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [7:0] id;
    rpt_bytes_t bytes;
  } rpt_event_t;

  function automatic logic [4:0] length_of(input logic [7:0] id);
    logic [4:0] len;
    case (id) inside
      8'h01, 8'h02, 8'h03, 8'h04, 8'h06:                      len = 5'd10;
      8'h05, 8'h09, 8'h28, 8'h2A:                             len = 5'd14;
      8'h07, 8'h0F, 8'h14, 8'h15, 8'h16, 8'hF1:               len = 5'd16;
      8'h08, 8'h11, 8'h29:                                    len = 5'd12;
      8'h10, 8'hFA:                                           len = 5'd5;
      8'h12, 8'h13, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1F, 8'h20: len = 5'd6;
      8'h18:                                                  len = 5'd8;
      default:                                                len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic gives_result(input logic [7:0] id);
    logic res;
    case (id) inside
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
      8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'hF1: res = 1'b1;
      default:                                                       res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/shrp_front.sv @@
// ----------------------------------------------------------------------------
// shrp_front
// framing, preamble skip, report split and byte capture; emits report events
// ----------------------------------------------------------------------------
module shrp_front import shrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] preamble_skip,
  input  logic       accept,
  input  logic [7:0] payload_byte,
  input  logic       packet_start,
  input  logic       packet_end,
  output logic       ev_valid,
  output rpt_event_t ev
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [4:0]       off_r, off_nxt;
  logic [4:0]       len_r, len_nxt;
  logic [7:0]       cur_id_r, cur_id_nxt;
  logic             halted_r, halted_nxt;
  logic             in_rpt_r, in_rpt_nxt;
  rpt_bytes_t       bytes_r, bytes_nxt;
  logic [4:0]       new_len;

  always_comb begin
    pos_nxt    = packet_start ? '0 : pos_r;
    off_nxt    = packet_start ? '0 : off_r;
    len_nxt    = packet_start ? '0 : len_r;
    halted_nxt = packet_start ? 1'b0 : halted_r;
    in_rpt_nxt = packet_start ? 1'b0 : in_rpt_r;
    cur_id_nxt = cur_id_r;
    bytes_nxt  = bytes_r;
    new_len    = length_of(payload_byte);
    ev_valid   = 1'b0;
    ev.outcome = OUTC_DECODED;

    if (pos_nxt < POS_W'(MAX_PACKET_BYTES)) begin
      if (halted_nxt) begin
        // rest of packet ignored
      end else if (in_rpt_nxt) begin
        bytes_nxt[off_nxt[3:0]] = payload_byte;
        off_nxt = off_nxt + 5'd1;
        if (off_nxt >= len_nxt) begin
          in_rpt_nxt = 1'b0;
          ev_valid   = gives_result(cur_id_nxt);
          ev.outcome = OUTC_DECODED;
        end
      end else if (pos_nxt >= POS_W'(preamble_skip)) begin
        cur_id_nxt = payload_byte;
        if (new_len == 5'd0) begin
          halted_nxt = 1'b1;
          ev_valid   = 1'b1;
          ev.outcome = OUTC_UNKNOWN;
        end else begin
          off_nxt    = 5'd1;
          len_nxt    = new_len;
          in_rpt_nxt = 1'b1;
        end
      end
      pos_nxt = pos_nxt + POS_W'(1);
      if (in_rpt_nxt && (packet_end || pos_nxt >= POS_W'(MAX_PACKET_BYTES))) begin
        in_rpt_nxt = 1'b0;
        ev_valid   = 1'b1;
        ev.outcome = OUTC_TRUNCATED;
      end
    end

    if (packet_end) begin
      pos_nxt    = '0;
      off_nxt    = '0;
      len_nxt    = '0;
      halted_nxt = 1'b0;
      in_rpt_nxt = 1'b0;
    end

    ev.id    = cur_id_nxt;
    ev.bytes = bytes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      off_r    <= '0;
      len_r    <= '0;
      cur_id_r <= '0;
      halted_r <= 1'b0;
      in_rpt_r <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      off_r    <= off_nxt;
      len_r    <= len_nxt;
      cur_id_r <= cur_id_nxt;
      halted_r <= halted_nxt;
      in_rpt_r <= in_rpt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bytes_r <= bytes_nxt;
    end
  end

endmodule

@@ rtl/shrp_queue.sv @@
// ----------------------------------------------------------------------------
// shrp_queue
// short event queue between front and back
// ----------------------------------------------------------------------------
module shrp_queue import shrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rpt_event_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output rpt_event_t head_data
);

  rpt_event_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/shrp_back.sv @@
// ----------------------------------------------------------------------------
// shrp_back
// field decode per report id into the output register
// ----------------------------------------------------------------------------
module shrp_back import shrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  rpt_event_t  head_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  outcome,
  output logic [7:0]  report_id,
  output logic [7:0]  seq_num,
  output logic [7:0]  status_value,
  output logic [15:0] word_a,
  output logic [15:0] word_b,
  output logic [15:0] word_c,
  output logic [15:0] word_d,
  output logic [15:0] word_e,
  output logic [15:0] word_f
);

  logic        valid_r;
  logic [1:0]  outcome_r;
  logic [7:0]  id_r, seq_r, status_r;
  logic [15:0] wa_r, wb_r, wc_r, wd_r, we_r, wf_r;
  logic [7:0]  seq_nxt, status_nxt;
  logic [15:0] wa_nxt, wb_nxt, wc_nxt, wd_nxt, we_nxt, wf_nxt;
  rpt_bytes_t  bt;
  logic [15:0] w4, w6, w8, w10, w12, w14;

  assign pop = head_valid && (!valid_r || out_ready);
  assign bt  = head_data.bytes;
  assign w4  = {bt[5], bt[4]};
  assign w6  = {bt[7], bt[6]};
  assign w8  = {bt[9], bt[8]};
  assign w10 = {bt[11], bt[10]};
  assign w12 = {bt[13], bt[12]};
  assign w14 = {bt[15], bt[14]};

  always_comb begin
    seq_nxt    = '0;
    status_nxt = '0;
    wa_nxt     = '0;
    wb_nxt     = '0;
    wc_nxt     = '0;
    wd_nxt     = '0;
    we_nxt     = '0;
    wf_nxt     = '0;
    if (head_data.outcome == OUTC_DECODED) begin
      seq_nxt    = bt[1];
      status_nxt = {6'd0, bt[2][1:0]};
      case (head_data.id) inside
        8'h01, 8'h02, 8'h03, 8'h04, 8'h06, 8'h14, 8'h15, 8'h16: begin
          wa_nxt = w4;
          wb_nxt = w6;
          wc_nxt = w8;
        end
        8'h05, 8'h09: begin
          wa_nxt = w4;
          wb_nxt = w6;
          wc_nxt = w8;
          wd_nxt = w10;
          we_nxt = w12;
        end
        8'h07, 8'h0F: begin
          wa_nxt = w4;
          wb_nxt = w6;
          wc_nxt = w8;
          wd_nxt = w10;
          we_nxt = w12;
          wf_nxt = w14;
        end
        8'h08: begin
          wa_nxt = w4;
          wb_nxt = w6;
          wc_nxt = w8;
          wd_nxt = w10;
          we_nxt = 16'hFFFF;
        end
        8'h10, 8'h13: begin
          wa_nxt = {8'd0, bt[4]};
        end
        8'h11: begin
          wa_nxt = w8;
        end
        8'h12: begin
          wa_nxt = w4;
        end
        8'hF1: begin
          status_nxt = bt[5];
          wa_nxt     = {8'd0, bt[3]};
          wb_nxt     = {8'd0, bt[4]};
          wc_nxt     = {8'd0, bt[6]};
          wd_nxt     = {8'd0, bt[7]};
          we_nxt     = {8'd0, bt[8]};
        end
        default: begin
          seq_nxt = bt[1];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      outcome_r <= head_data.outcome;
      id_r      <= head_data.id;
      seq_r     <= seq_nxt;
      status_r  <= status_nxt;
      wa_r      <= wa_nxt;
      wb_r      <= wb_nxt;
      wc_r      <= wc_nxt;
      wd_r      <= wd_nxt;
      we_r      <= we_nxt;
      wf_r      <= wf_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign outcome      = outcome_r;
  assign report_id    = id_r;
  assign seq_num      = seq_r;
  assign status_value = status_r;
  assign word_a       = wa_r;
  assign word_b       = wb_r;
  assign word_c       = wc_r;
  assign word_d       = wd_r;
  assign word_e       = we_r;
  assign word_f       = wf_r;

endmodule

@@ rtl/sensor_hub_report_parser.sv @@
// ----------------------------------------------------------------------------
// sensor_hub_report_parser
// splits sensor hub packet payload into reports and decodes their fields
// ----------------------------------------------------------------------------
// input stream: one payload byte per beat, tuser marks the first byte of a
// packet, tlast the last. the first preamble_skip bytes of each packet are
// skipped, the rest is cut into reports by id. cfg_valid/cfg_data writes
// preamble_skip (reset 5); cfg_ready is always high.
// output stream: one beat per decoded report of a result-giving id, unknown
// id (rest of packet dropped) or truncated report, outcome in tuser.
// throughput: one byte per cycle while the queue is not full; a byte that
// completes a report gives its result after acceptance as follows: the front
// captures the byte and pushes an event into a two-entry queue, the back
// decodes it into the output register.
// out_tready low: results wait in the output register and the queue; the
// input keeps taking bytes until the queue is full, then in_tready drops.
// reset: clears packet state and queue, preamble_skip returns to 5.
// ----------------------------------------------------------------------------
module sensor_hub_report_parser import shrp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // payload_byte
  input  logic         in_tuser,   // packet_start
  input  logic         in_tlast,   // packet_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // report_id, seq_num, status_value, word_a..word_f
  output logic [1:0]   out_tuser,  // outcome
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data    // preamble_skip
);

  logic [4:0]  skip_r;
  logic        accept;
  logic        ev_valid;
  rpt_event_t  ev;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  rpt_event_t  q_head;
  logic [7:0]  report_id, seq_num, status_value;
  logic [15:0] word_a, word_b, word_c, word_d, word_e, word_f;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      skip_r <= cfg_data;
    end
  end

  shrp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .preamble_skip (skip_r),
    .accept        (accept),
    .payload_byte  (in_tdata),
    .packet_start  (in_tuser),
    .packet_end    (in_tlast),
    .ev_valid      (ev_valid),
    .ev            (ev)
  );

  shrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && ev_valid),
    .push_data  (ev),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  shrp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_valid),
    .head_data    (q_head),
    .pop          (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .outcome      (out_tuser),
    .report_id    (report_id),
    .seq_num      (seq_num),
    .status_value (status_value),
    .word_a       (word_a),
    .word_b       (word_b),
    .word_c       (word_c),
    .word_d       (word_d),
    .word_e       (word_e),
    .word_f       (word_f)
  );

  assign out_tdata = {word_f, word_e, word_d, word_c, word_b, word_a,
                      status_value, seq_num, report_id};

endmodule

@@ sim/sensor_hub_report_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_hub_report_parser_test
// self-checking bench: packets of payload bytes in, parsed reports out
// ----------------------------------------------------------------------------
// a tracker mirrors the parser byte by byte and queues the report it should
// emit. stimulus is a short hand-made run, then mostly well-formed packets
// with random content mixed with broken framing, unknown ids, cut reports,
// noise and one packet past the byte limit. both sides stall at random outside
// the last two phases, preamble_skip is rewritten between phases when idle.
// ----------------------------------------------------------------------------
module sensor_hub_report_parser_test import shrp_pkg::*; ();

  localparam int SEG_ITEMS      = 320;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [7:0] KNOWN_IDS [29] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0F,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'hF1, 8'h18, 8'h19,
    8'h1A, 8'h1B, 8'h1C, 8'h1F, 8'h20, 8'h28, 8'h29, 8'h2A, 8'hFA
  };

  typedef struct packed {
    outcome_t         outcome;
    logic [5:0][15:0] words;  // words[0] is word_a
    logic [7:0]       status;
    logic [7:0]       seq;
    logic [7:0]       id;
  } report_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sop;
    logic       eop;
  } beat_t;

  class report_tracker;
    logic [4:0] skip = SKIP_RESET;
    int         pos;
    int         offs;
    int         len;
    logic [7:0] cur_id;
    bit         halted;
    bit         open_rpt;
    logic [7:0] rbytes [16];
    report_t    awaited [$];
    int         fails;

    function int report_len(logic [7:0] id);
      case (id)
        8'h01, 8'h02, 8'h03, 8'h04, 8'h06:                      return 10;
        8'h05, 8'h09, 8'h28, 8'h2A:                             return 14;
        8'h07, 8'h0F, 8'h14, 8'h15, 8'h16, 8'hF1:               return 16;
        8'h08, 8'h11, 8'h29:                                    return 12;
        8'h10, 8'hFA:                                           return 5;
        8'h12, 8'h13, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1F, 8'h20: return 6;
        8'h18:                                                  return 8;
        default:                                                return 0;
      endcase
    endfunction

    function logic [15:0] word_at(int lo);
      return {rbytes[(lo + 1) % 16], rbytes[lo % 16]};
    endfunction

    function report_t blank(outcome_t oc, logic [7:0] id);
      report_t rpt;
      rpt         = '0;
      rpt.outcome = oc;
      rpt.id      = id;
      return rpt;
    endfunction

    function void clear_packet();
      pos      = 0;
      offs     = 0;
      len      = 0;
      halted   = 0;
      open_rpt = 0;
    endfunction

    // completed report: detector and rebase ids give nothing
    function void decode();
      report_t rpt;
      rpt        = blank(OUTC_DECODED, cur_id);
      rpt.seq    = rbytes[1];
      rpt.status = rbytes[2] & 8'h03;
      case (cur_id)
        8'h01, 8'h02, 8'h03, 8'h04, 8'h06, 8'h14, 8'h15, 8'h16: begin
          for (int i = 0; i < 3; i++) rpt.words[i] = word_at(4 + 2 * i);
        end
        8'h05, 8'h09: begin
          for (int i = 0; i < 5; i++) rpt.words[i] = word_at(4 + 2 * i);
        end
        8'h07, 8'h0F: begin
          for (int i = 0; i < 6; i++) rpt.words[i] = word_at(4 + 2 * i);
        end
        8'h08: begin
          for (int i = 0; i < 4; i++) rpt.words[i] = word_at(4 + 2 * i);
          rpt.words[4] = 16'hFFFF;
        end
        8'h10, 8'h13: rpt.words[0] = {8'h00, rbytes[4]};
        8'h11:        rpt.words[0] = word_at(8);
        8'h12:        rpt.words[0] = word_at(4);
        8'hF1: begin
          rpt.status   = rbytes[5];
          rpt.words[0] = {8'h00, rbytes[3]};
          rpt.words[1] = {8'h00, rbytes[4]};
          rpt.words[2] = {8'h00, rbytes[6]};
          rpt.words[3] = {8'h00, rbytes[7]};
          rpt.words[4] = {8'h00, rbytes[8]};
        end
        default: return;
      endcase
      awaited.push_back(rpt);
    endfunction

    function void take_byte(logic [7:0] b, bit sop, bit eop);
      int n_len;
      if (sop) clear_packet();
      if (pos < MAX_PACKET_BYTES) begin
        if (!halted) begin
          if (open_rpt) begin
            rbytes[offs % 16] = b;
            offs = (offs + 1) % 32;
            if (offs >= len) begin
              open_rpt = 0;
              decode();
            end
          end else if (pos >= skip) begin
            n_len  = report_len(b);
            cur_id = b;
            if (n_len == 0) begin
              halted = 1;
              awaited.push_back(blank(OUTC_UNKNOWN, b));
            end else begin
              rbytes[0] = b;
              offs      = 1;
              len       = n_len;
              open_rpt  = 1;
            end
          end
        end
        pos++;
        if (open_rpt && (eop || pos >= MAX_PACKET_BYTES)) begin
          open_rpt = 0;
          awaited.push_back(blank(OUTC_TRUNCATED, cur_id));
        end
      end
      if (eop) clear_packet();
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t %s: expected %h actual %h", $time, name, want, got);
        fails++;
      end
    endfunction

    function void match_result(logic [1:0] tuser, logic [119:0] tdata);
      report_t want;
      report_t got;
      if (awaited.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h %h", $time, tuser, tdata);
        fails++;
        return;
      end
      want = awaited.pop_front();
      got  = {tuser, tdata};
      check_field("outcome", want.outcome, got.outcome);
      check_field("report_id", want.id, got.id);
      check_field("seq_num", want.seq, got.seq);
      check_field("status_value", want.status, got.status);
      for (int i = 0; i < 6; i++)
        check_field($sformatf("word_%c", 8'h61 + i), want.words[i], got.words[i]);
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;  // payload_byte
  logic         in_tuser   = 1'b0;  // packet_start
  logic         in_tlast   = 1'b0;  // packet_end
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;  // report_id, seq_num, status_value, word_a..word_f
  logic [1:0]   out_tuser;  // outcome
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [4:0]   cfg_data   = '0;  // preamble_skip

  report_tracker tracker = new();
  beat_t         burst [$];
  int            tx_idle_pct = 38;
  int            rx_idle_pct = 51;
  int            sent;
  int            stall_cycles;

  sensor_hub_report_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.match_result(out_tuser, out_tdata);
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no beat for %0d cycles", $time, stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic void push_beat(logic [7:0] data, logic sop, logic eop);
    burst.push_back('{data: data, sop: sop, eop: eop});
  endfunction

  function automatic void add_report(logic [7:0] id);
    push_beat(id, 1'b0, 1'b0);
    repeat (tracker.report_len(id) - 1) push_beat(rand_byte(), 1'b0, 1'b0);
  endfunction

  function automatic void make_packet(int skip_now);
    int         kind;
    int         n;
    logic [7:0] id;
    kind = $urandom_range(99);
    if (kind >= 92) begin
      // noise with random marks
      n = $urandom_range(1, 20);
      repeat (n) push_beat(rand_byte(), $urandom_range(3) == 0, $urandom_range(5) == 0);
      return;
    end
    repeat (skip_now) push_beat(rand_byte(), 1'b0, 1'b0);
    n = $urandom_range(1, 4);
    repeat (n) add_report(KNOWN_IDS[$urandom_range(28)]);
    if (kind >= 60 && kind < 70) begin
      do id = 8'($urandom_range(255)); while (tracker.report_len(id) != 0);
      push_beat(id, 1'b0, 1'b0);
      repeat ($urandom_range(3)) push_beat(rand_byte(), 1'b0, 1'b0);
    end else if (kind >= 70 && kind < 80) begin
      n = $urandom_range(1, 9);
      repeat (n) if (burst.size() > 1) void'(burst.pop_back());
    end
    if (kind < 87) burst[0].sop = 1'b1;
    if (kind < 80 || kind >= 87) burst[burst.size() - 1].eop = 1'b1;
  endfunction

  task automatic send_beat(logic [7:0] data, logic sop, logic eop);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= sop;
    in_tlast  <= eop;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(data, sop, eop);
    sent++;
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_beat(burst[i].data, burst[i].sop, burst[i].eop);
    burst.delete();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_skip(logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.skip = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         seg_end;
    logic [4:0] seg_skip [6];
    seg_skip = '{5'd31, 5'd3, 5'd0, 5'($urandom_range(31)), 5'd1, 5'd5};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_skip(5'd0);

    // single byte packet, extremes, unknown id, detector report, lost end mark
    push_beat(8'h10, 1'b1, 1'b1);
    push_beat(8'h10, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h03, 1'b0, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b1);
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'h01, 1'b0, 1'b1);
    push_beat(8'hFA, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h80, 1'b0, 1'b0);
    push_beat(8'h7F, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h12, 1'b0, 1'b1);
    push_beat(8'h01, 1'b1, 1'b0);
    push_beat(8'h7F, 1'b0, 1'b0);
    push_beat(8'h80, 1'b0, 1'b0);
    push_beat(8'h13, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h80, 1'b0, 1'b0);
    push_beat(8'h7F, 1'b0, 1'b0);
    push_beat(8'h01, 1'b0, 1'b1);
    send_burst();

    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      write_skip(seg_skip[seg]);
      tx_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 51 : 0;
      rx_idle_pct = (seg < 2) ? 51 : (seg < 4) ? 38 : 0;
      seg_end = sent + SEG_ITEMS;
      if (seg == 2) begin
        // runs past the byte limit
        repeat (seg_skip[seg]) push_beat(rand_byte(), 1'b0, 1'b0);
        while (burst.size() < 530) add_report(KNOWN_IDS[$urandom_range(28)]);
        burst[0].sop = 1'b1;
        burst[burst.size() - 1].eop = 1'b1;
        send_burst();
      end
      while (sent < seg_end) begin
        if ($urandom_range(29) == 0) wait_drained();
        make_packet(tracker.skip);
        send_burst();
      end
    end

    wait_drained();
    tracker.fails += tracker.awaited.size();
    if (tracker.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
